// File: hdl/asf_pkg.sv
// Shared types, constants and helper functions of the angular spring force pipeline.
package asf_pkg;

    localparam int FIX_W  = 32;
    localparam int ANG_W  = 25;
    localparam int N_IN   = 12;
    localparam int IN_W   = N_IN * FIX_W;
    localparam int OUT_W  = 160;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_REST  = 2'd0,
        REG_STIFF = 2'd1,
        REG_DAMP  = 2'd2
    } t_reg_idx;

    localparam logic signed [31:0] ARM_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] ARM_MIN = 32'sh8000_0001;

    localparam logic signed [25:0] DEG90  = 26'sd5898240;
    localparam logic signed [25:0] DEG180 = 26'sd11796480;

    // Square root: one result bit per stage
    localparam int SQRT_STEPS = 32;
    localparam int SQRT_LAT   = SQRT_STEPS;

    // Divider: quotient bits per stage, plus a sign stage
    localparam int DIV_STEPS  = 31;
    localparam int DIV_PER    = 2;
    localparam int DIV_STAGES = (DIV_STEPS + DIV_PER - 1) / DIV_PER;
    localparam int DIV_LAT    = DIV_STAGES + 1;

    // Angle unit: magnitude stage, normalize stages, rotation stages, fold stage
    localparam int NORM_STEPS    = 6;
    localparam int NORM_PER      = 2;
    localparam int NORM_STAGES   = (NORM_STEPS + NORM_PER - 1) / NORM_PER;
    localparam int CORDIC_STEPS  = 20;
    localparam int CORDIC_PER    = 2;
    localparam int CORDIC_STAGES = (CORDIC_STEPS + CORDIC_PER - 1) / CORDIC_PER;
    localparam int CORDIC_LAT    = 1 + NORM_STAGES + CORDIC_STAGES + 1;

    localparam logic [21:0] ATAN_DEG [CORDIC_STEPS] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379,
        22'd117304,  22'd58666,   22'd29335,  22'd14668,  22'd7334,
        22'd3667,    22'd1833,    22'd917,    22'd458,    22'd229,
        22'd115,     22'd57,      22'd29,     22'd14,     22'd7
    };

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -66'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Difference a - b clamped to the symmetric 31-bit range
    function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic signed [32:0] d;
        logic signed [31:0] r;
        d = 33'(a) - 33'(b);
        if (d > 33'(ARM_MAX)) begin
            r = ARM_MAX;
        end else if (d < 33'(ARM_MIN)) begin
            r = ARM_MIN;
        end else begin
            r = d[31:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/asf_sqrt.sv
// Pipelined integer square root of a 64-bit value, one result bit per stage.
module asf_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_sq,
    output logic [31:0] o_root
);

    logic [63:0] r_n [asf_pkg::SQRT_STEPS];
    logic [63:0] r_r [asf_pkg::SQRT_STEPS];

    for (genvar g = 0; g < asf_pkg::SQRT_STEPS; g++) begin : g_step
        logic [63:0] w_n;
        logic [63:0] w_r;
        logic [63:0] w_bit;
        logic [63:0] w_trial;
        logic [63:0] n_n;
        logic [63:0] n_r;

        if (g == 0) begin : g_first
            assign w_n = i_sq;
            assign w_r = '0;
        end else begin : g_rest
            assign w_n = r_n[g-1];
            assign w_r = r_r[g-1];
        end

        assign w_bit   = 64'd1 << (62 - 2 * g);
        assign w_trial = w_r + w_bit;

        always_comb begin
            if (w_n >= w_trial) begin
                n_n = w_n - w_trial;
                n_r = (w_r >> 1) + w_bit;
            end else begin
                n_n = w_n;
                n_r = w_r >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[g] <= n_n;
                r_r[g] <= n_r;
            end
        end
    end

    assign o_root = r_r[asf_pkg::SQRT_STEPS-1][31:0];

endmodule

// File: hdl/asf_div.sv
// Pipelined restoring divider: signed arm component times 2^30 over arm length.
module asf_div (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_num,
    input  logic        [31:0] i_len,
    output logic signed [31:0] o_quo
);

    typedef struct packed {
        logic [31:0] rem;
        logic [30:0] q;
        logic [31:0] len;
        logic        neg;
    } t_div_st;

    function automatic t_div_st div_step(input t_div_st s, input logic fb);
        logic [32:0] tmp;
        t_div_st     r;
        r   = s;
        tmp = {s.rem, fb};
        if (tmp >= {1'b0, s.len}) begin
            r.rem = 32'(tmp - {1'b0, s.len});
            r.q   = {s.q[29:0], 1'b1};
        end else begin
            r.rem = tmp[31:0];
            r.q   = {s.q[29:0], 1'b0};
        end
        return r;
    endfunction

    logic [31:0]        w_mag;
    t_div_st            w_init;
    t_div_st            r_st [asf_pkg::DIV_STAGES];
    logic signed [31:0] r_quo;

    // Magnitude fits 31 bits: the arm is clamped to the symmetric range
    assign w_mag      = i_num[31] ? 32'(-i_num) : 32'(i_num);
    assign w_init.rem = {2'b00, w_mag[30:1]};
    assign w_init.q   = '0;
    assign w_init.len = i_len;
    assign w_init.neg = i_num[31];

    for (genvar g = 0; g < asf_pkg::DIV_STAGES; g++) begin : g_stage
        t_div_st w_src;
        t_div_st n_st;

        if (g == 0) begin : g_first
            assign w_src = w_init;
        end else begin : g_rest
            assign w_src = r_st[g-1];
        end

        always_comb begin
            n_st = w_src;
            for (int k = 0; k < asf_pkg::DIV_PER; k++) begin
                if (g * asf_pkg::DIV_PER + k < asf_pkg::DIV_STEPS) begin
                    n_st = div_step(n_st, (g == 0 && k == 0) ? w_mag[0] : 1'b0);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[g] <= n_st;
            end
        end
    end

    // Apply the sign: truncation toward zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_st[asf_pkg::DIV_STAGES-1].neg) begin
                r_quo <= -$signed({1'b0, r_st[asf_pkg::DIV_STAGES-1].q});
            end else begin
                r_quo <= $signed({1'b0, r_st[asf_pkg::DIV_STAGES-1].q});
            end
        end
    end

    assign o_quo = r_quo;

endmodule

// File: hdl/asf_cordic.sv
// Signed angle between the arms from dot and determinant, via vectoring CORDIC.
module asf_cordic (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_dot,
    input  logic signed [63:0] i_det,
    output logic signed [24:0] o_angle
);

    typedef struct packed {
        logic det_zero;
        logic dot_zero;
        logic dot_neg;
        logic det_neg;
    } t_flags;

    typedef struct packed {
        logic [63:0] dm;
        logic [63:0] tm;
        t_flags      f;
    } t_norm;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [25:0] z;
        t_flags             f;
    } t_rot;

    t_norm              r_mag;
    t_norm              r_nm  [asf_pkg::NORM_STAGES];
    t_rot               r_rot [asf_pkg::CORDIC_STAGES];
    logic signed [24:0] r_angle;

    // Take magnitudes and the quadrant flags
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag.dm         <= i_dot[63] ? 64'(-i_dot) : 64'(i_dot);
            r_mag.tm         <= i_det[63] ? 64'(-i_det) : 64'(i_det);
            r_mag.f.det_zero <= (i_det == '0);
            r_mag.f.dot_zero <= (i_dot == '0);
            r_mag.f.dot_neg  <= i_dot[63];
            r_mag.f.det_neg  <= i_det[63];
        end
    end

    // Shift both magnitudes right until the larger is below 2^30
    for (genvar g = 0; g < asf_pkg::NORM_STAGES; g++) begin : g_norm
        t_norm w_src;
        t_norm n_nm;

        if (g == 0) begin : g_first
            assign w_src = r_mag;
        end else begin : g_rest
            assign w_src = r_nm[g-1];
        end

        always_comb begin
            int j;
            int s;
            n_nm = w_src;
            for (int k = 0; k < asf_pkg::NORM_PER; k++) begin
                j = g * asf_pkg::NORM_PER + k;
                if (j < asf_pkg::NORM_STEPS) begin
                    s = 1 << (asf_pkg::NORM_STEPS - 1 - j);
                    if (((n_nm.dm >> (29 + s)) != '0) || ((n_nm.tm >> (29 + s)) != '0)) begin
                        n_nm.dm = n_nm.dm >> s;
                        n_nm.tm = n_nm.tm >> s;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nm[g] <= n_nm;
            end
        end
    end

    // Rotate the vector onto the x axis, accumulating the angle
    for (genvar g = 0; g < asf_pkg::CORDIC_STAGES; g++) begin : g_rot
        t_rot w_src;
        t_rot n_rot;

        if (g == 0) begin : g_first
            assign w_src.x = $signed({4'b0000, r_nm[asf_pkg::NORM_STAGES-1].dm[29:0]});
            assign w_src.y = $signed({4'b0000, r_nm[asf_pkg::NORM_STAGES-1].tm[29:0]});
            assign w_src.z = '0;
            assign w_src.f = r_nm[asf_pkg::NORM_STAGES-1].f;
        end else begin : g_rest
            assign w_src = r_rot[g-1];
        end

        always_comb begin
            int i;
            logic signed [33:0] xs;
            logic signed [33:0] ys;
            n_rot = w_src;
            for (int k = 0; k < asf_pkg::CORDIC_PER; k++) begin
                i = g * asf_pkg::CORDIC_PER + k;
                if (i < asf_pkg::CORDIC_STEPS) begin
                    xs = n_rot.x >>> i;
                    ys = n_rot.y >>> i;
                    if (!n_rot.y[33]) begin
                        n_rot.x = n_rot.x + ys;
                        n_rot.y = n_rot.y - xs;
                        n_rot.z = n_rot.z + $signed({4'b0000, asf_pkg::ATAN_DEG[i]});
                    end else begin
                        n_rot.x = n_rot.x - ys;
                        n_rot.y = n_rot.y + xs;
                        n_rot.z = n_rot.z - $signed({4'b0000, asf_pkg::ATAN_DEG[i]});
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rot[g] <= n_rot;
            end
        end
    end

    // Clamp, handle collinear and perpendicular arms, fold into the full range
    always_ff @(posedge i_clk) begin
        logic signed [25:0] alpha;
        logic signed [25:0] rs;
        t_rot               last;
        last = r_rot[asf_pkg::CORDIC_STAGES-1];
        if (last.f.det_zero) begin
            alpha = '0;
        end else if (last.f.dot_zero) begin
            alpha = asf_pkg::DEG90;
        end else if (last.z < 0) begin
            alpha = '0;
        end else if (last.z > asf_pkg::DEG90) begin
            alpha = asf_pkg::DEG90;
        end else begin
            alpha = last.z;
        end
        rs = last.f.dot_neg ? asf_pkg::DEG180 - alpha : alpha;
        if (i_en) begin
            r_angle <= last.f.det_neg ? 25'(-rs) : 25'(rs);
        end
    end

    assign o_angle = r_angle;

endmodule

// File: hdl/angular_spring_force.sv
// Top level of the angular spring force pipeline with its register port.
//
// Angular spring between three 2D particles, Q16.16 throughout. One spring
// (three positions and three velocities, packed on s_axis_tdata) enters per
// clock cycle unless the output stalls; its result is the four saturated
// force increments and the signed angle on m_axis_tdata, the zero-length arm
// flag on m_axis_tuser. The length path is the longer one: the arm, product
// and sum stages, a 32-stage square root (one root bit per stage), and a
// 17-stage divider that forms the unit arm vectors, then the force product
// and sum registers. The angle path (magnitudes, normalizing shift, 20-step
// CORDIC in 10 stages) runs alongside and is delayed to meet it. A stall on
// m_axis_tready holds every stage at once, so nothing is lost or repeated.
// Rest angle, stiffness and damping are written over the APB port; write
// them only while no spring is in flight.
module angular_spring_force (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Register port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    // Input stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // tdata from bit 0: first_pos_x, first_pos_y, middle_pos_x, middle_pos_y,
    // third_pos_x, third_pos_y, first_vel_x, first_vel_y, middle_vel_x,
    // middle_vel_y, third_vel_x, third_vel_y (32 bits each)
    input  logic [asf_pkg::IN_W-1:0]  s_axis_tdata,
    // Output stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // tdata from bit 0: first_force_dx, first_force_dy, third_force_dx,
    // third_force_dy (32 bits each), signed_angle (25 bits), zero pad
    output logic [asf_pkg::OUT_W-1:0] m_axis_tdata,
    // tuser: degenerate
    output logic                      m_axis_tuser
);

    localparam int T_L      = 3 + asf_pkg::SQRT_LAT;
    localparam int T_U      = T_L + asf_pkg::DIV_LAT;
    localparam int T_RS     = 3 + asf_pkg::CORDIC_LAT;
    localparam int T_K      = T_RS + 3;
    localparam int LAST     = T_U + 2;
    localparam int ARM_DLY  = T_L - 1;
    localparam int SIDE_DLY = T_U - 1;
    localparam int RS_DLY   = T_U - T_RS;
    localparam int K_DLY    = T_U - T_K;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
    } t_arms;

    typedef struct packed {
        logic signed [31:0] v1x;
        logic signed [31:0] v1y;
        logic signed [31:0] v3x;
        logic signed [31:0] v3y;
        logic               degen;
    } t_side;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [23:0] r_rest;
    logic [30:0] r_stiff;
    logic [30:0] r_damp;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest  <= '0;
            r_stiff <= '0;
            r_damp  <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                asf_pkg::REG_REST:  r_rest  <= pwdata[23:0];
                asf_pkg::REG_STIFF: r_stiff <= pwdata[30:0];
                asf_pkg::REG_DAMP:  r_damp  <= pwdata[30:0];
                default: ;  // unmapped address: drop the write
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            asf_pkg::REG_REST:  prdata = {8'b0, r_rest};
            asf_pkg::REG_STIFF: prdata = {1'b0, r_stiff};
            asf_pkg::REG_DAMP:  prdata = {1'b0, r_damp};
            default:            prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Pipeline control: one enable for all stages, valid bits alongside
    // ---------------------------------------------------------------
    logic            w_en;
    logic [LAST-1:0] r_vld;

    assign w_en          = !r_vld[LAST-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LAST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-2:0], s_axis_tvalid};
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: arms, relative velocities, zero-length test
    // ---------------------------------------------------------------
    logic signed [31:0] w_in [asf_pkg::N_IN];
    t_arms              r1_arm;
    t_side              r1_side;

    for (genvar f = 0; f < asf_pkg::N_IN; f++) begin : g_unpack
        assign w_in[f] = s_axis_tdata[f*asf_pkg::FIX_W +: asf_pkg::FIX_W];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_arm.ax     <= asf_pkg::sat_diff(w_in[0], w_in[2]);
            r1_arm.ay     <= asf_pkg::sat_diff(w_in[1], w_in[3]);
            r1_arm.bx     <= asf_pkg::sat_diff(w_in[4], w_in[2]);
            r1_arm.by     <= asf_pkg::sat_diff(w_in[5], w_in[3]);
            r1_side.v1x   <= asf_pkg::sat_diff(w_in[6], w_in[8]);
            r1_side.v1y   <= asf_pkg::sat_diff(w_in[7], w_in[9]);
            r1_side.v3x   <= asf_pkg::sat_diff(w_in[10], w_in[8]);
            r1_side.v3y   <= asf_pkg::sat_diff(w_in[11], w_in[9]);
            // A clamped difference is zero only when the two positions match
            r1_side.degen <= ((w_in[0] == w_in[2]) && (w_in[1] == w_in[3])) ||
                             ((w_in[4] == w_in[2]) && (w_in[5] == w_in[3]));
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: squares and cross products
    // ---------------------------------------------------------------
    logic signed [63:0] r2_sq_ax, r2_sq_ay, r2_sq_bx, r2_sq_by;
    logic signed [63:0] r2_axbx, r2_ayby, r2_axby, r2_aybx;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_sq_ax <= r1_arm.ax * r1_arm.ax;
            r2_sq_ay <= r1_arm.ay * r1_arm.ay;
            r2_sq_bx <= r1_arm.bx * r1_arm.bx;
            r2_sq_by <= r1_arm.by * r1_arm.by;
            r2_axbx  <= r1_arm.ax * r1_arm.bx;
            r2_ayby  <= r1_arm.ay * r1_arm.by;
            r2_axby  <= r1_arm.ax * r1_arm.by;
            r2_aybx  <= r1_arm.ay * r1_arm.bx;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: squared lengths, dot product, determinant
    // ---------------------------------------------------------------
    logic [63:0]        r3_lsq1, r3_lsq3;
    logic signed [63:0] r3_dot, r3_det;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_lsq1 <= $unsigned(r2_sq_ax + r2_sq_ay);
            r3_lsq3 <= $unsigned(r2_sq_bx + r2_sq_by);
            r3_dot  <= r2_axbx + r2_ayby;
            r3_det  <= r2_axby - r2_aybx;
        end
    end

    // ---------------------------------------------------------------
    // Length path: square roots, then unit arm components
    // ---------------------------------------------------------------
    logic [31:0]        w_len1, w_len3;
    t_arms              r_arm_d [ARM_DLY];
    logic signed [31:0] w_u_ax, w_u_ay, w_u_bx, w_u_by;

    asf_sqrt u_sqrt1 (.i_clk(i_clk), .i_en(w_en), .i_sq(r3_lsq1), .o_root(w_len1));
    asf_sqrt u_sqrt3 (.i_clk(i_clk), .i_en(w_en), .i_sq(r3_lsq3), .o_root(w_len3));

    // Hold the arms until the lengths arrive
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_arm_d[0] <= r1_arm;
            for (int i = 1; i < ARM_DLY; i++) begin
                r_arm_d[i] <= r_arm_d[i-1];
            end
        end
    end

    asf_div u_div_ax (.i_clk(i_clk), .i_en(w_en), .i_num(r_arm_d[ARM_DLY-1].ax),
                      .i_len(w_len1), .o_quo(w_u_ax));
    asf_div u_div_ay (.i_clk(i_clk), .i_en(w_en), .i_num(r_arm_d[ARM_DLY-1].ay),
                      .i_len(w_len1), .o_quo(w_u_ay));
    asf_div u_div_bx (.i_clk(i_clk), .i_en(w_en), .i_num(r_arm_d[ARM_DLY-1].bx),
                      .i_len(w_len3), .o_quo(w_u_bx));
    asf_div u_div_by (.i_clk(i_clk), .i_en(w_en), .i_num(r_arm_d[ARM_DLY-1].by),
                      .i_len(w_len3), .o_quo(w_u_by));

    // ---------------------------------------------------------------
    // Angle path: signed angle, angular error, stiffness gain
    // ---------------------------------------------------------------
    logic signed [24:0] w_rs;
    logic signed [25:0] r_err;
    logic signed [57:0] r_kprod;
    logic signed [31:0] r_k;
    logic signed [31:0] r_k_d  [K_DLY];
    logic signed [24:0] r_rs_d [RS_DLY];

    asf_cordic u_cordic (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_dot  (r3_dot),
        .i_det  (r3_det),
        .o_angle(w_rs)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // A zero angle counts as non-negative
            if (w_rs[24]) begin
                r_err <= 26'(w_rs) + $signed({2'b00, r_rest});
            end else begin
                r_err <= 26'(w_rs) - $signed({2'b00, r_rest});
            end
            r_kprod <= $signed({1'b0, r_stiff}) * r_err;
            r_k     <= asf_pkg::sat32(66'(r_kprod >>> 16));
        end
    end

    // Align gain and angle with the unit vectors
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k_d[0]  <= r_k;
            r_rs_d[0] <= w_rs;
            for (int i = 1; i < K_DLY; i++) begin
                r_k_d[i] <= r_k_d[i-1];
            end
            for (int i = 1; i < RS_DLY; i++) begin
                r_rs_d[i] <= r_rs_d[i-1];
            end
        end
    end

    // Velocities and the degenerate flag ride along
    t_side r_side_d [SIDE_DLY];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side_d[0] <= r1_side;
            for (int i = 1; i < SIDE_DLY; i++) begin
                r_side_d[i] <= r_side_d[i-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Force products: spring and damping terms
    // ---------------------------------------------------------------
    logic signed [63:0] r5_s_ax, r5_s_ay, r5_s_bx, r5_s_by;
    logic signed [63:0] r5_d_v1x, r5_d_v1y, r5_d_v3x, r5_d_v3y;
    logic signed [24:0] r5_rs;
    logic               r5_degen;
    logic signed [31:0] w_damp;
    t_side              w_side;
    logic signed [31:0] w_k;

    assign w_damp = $signed({1'b0, r_damp});
    assign w_side = r_side_d[SIDE_DLY-1];
    assign w_k    = r_k_d[K_DLY-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_s_ax  <= w_k * w_u_ax;
            r5_s_ay  <= w_k * w_u_ay;
            r5_s_bx  <= w_k * w_u_bx;
            r5_s_by  <= w_k * w_u_by;
            r5_d_v1x <= w_damp * w_side.v1x;
            r5_d_v1y <= w_damp * w_side.v1y;
            r5_d_v3x <= w_damp * w_side.v3x;
            r5_d_v3y <= w_damp * w_side.v3y;
            r5_rs    <= r_rs_d[RS_DLY-1];
            r5_degen <= w_side.degen;
        end
    end

    // ---------------------------------------------------------------
    // Output register: combine, saturate, zero on a degenerate spring
    // ---------------------------------------------------------------
    function automatic logic signed [31:0] comb_force(input logic signed [63:0] sp,
                                                      input logic signed [63:0] dp,
                                                      input logic               neg);
        logic signed [65:0] s;
        logic signed [65:0] d;
        s = 66'(sp) >>> 30;
        d = 66'(dp) >>> 16;
        return asf_pkg::sat32(neg ? (-s - d) : (s - d));
    endfunction

    logic signed [31:0] r_o_f0, r_o_f1, r_o_f2, r_o_f3;
    logic signed [24:0] r_o_angle;
    logic               r_o_degen;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r5_degen) begin
                r_o_f0    <= '0;
                r_o_f1    <= '0;
                r_o_f2    <= '0;
                r_o_f3    <= '0;
                r_o_angle <= '0;
            end else begin
                r_o_f0    <= comb_force(r5_s_ay, r5_d_v1x, 1'b1);
                r_o_f1    <= comb_force(r5_s_ax, r5_d_v1y, 1'b0);
                r_o_f2    <= comb_force(r5_s_by, r5_d_v3x, 1'b0);
                r_o_f3    <= comb_force(r5_s_bx, r5_d_v3y, 1'b1);
                r_o_angle <= r5_rs;
            end
            r_o_degen <= r5_degen;
        end
    end

    assign m_axis_tdata = {7'b0, r_o_angle, r_o_f3, r_o_f2, r_o_f1, r_o_f0};
    assign m_axis_tuser = r_o_degen;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == '0))
        else $error("degenerate result carries nonzero data");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(r_o_angle) <= 25'sd11796480) &&
                          ($signed(r_o_angle) >= -25'sd11796480))
        else $error("signed angle outside half turn");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the angular spring force pipeline.
`timescale 1ns / 1ps

module testbench;

    localparam int  RAND_PER_PHASE = 235;
    localparam int  N_PHASES       = 6;
    localparam int  CYCLE_LIMIT    = 400000;
    localparam int  DRAIN_CYCLES   = 80;
    localparam longint ARM_LIM     = 64'sd2147483647;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [3:0]                   paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [asf_pkg::IN_W-1:0]     s_axis_tdata;   // 12 x 32: pos x,y then vel x,y
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [asf_pkg::OUT_W-1:0]    m_axis_tdata;   // 4 forces x 32, signed_angle 25, pad
    logic                         m_axis_tuser;   // degenerate

    angular_spring_force dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Expected result: degenerate flag on top, then the output tdata layout
    typedef logic [asf_pkg::OUT_W:0] t_force_result;

    logic [asf_pkg::IN_W-1:0] spring_queue[$];     // springs waiting to be driven
    t_force_result            force_queue[$];      // predictions waiting for the output
    longint          model_rest;
    longint          model_stiff;
    longint          model_damp;
    int              snd_idle_pct;
    int              rcv_stall_pct;
    int              mismatches;
    int              results_seen;
    int              degen_seen;
    int              cycles;

    // ------------------------------------------------------------------
    // Force predictor
    // ------------------------------------------------------------------
    function automatic longint clip_diff(logic signed [31:0] a, logic signed [31:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d > ARM_LIM) d = ARM_LIM;
        if (d < -ARM_LIM) d = -ARM_LIM;
        return d;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned bt;
        r  = 0;
        bt = 64'd1 << 62;
        while (bt != 0) begin
            if (n >= r + bt) begin
                n = n - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    // atan(adet/adot) in degrees Q16.16, 20 CORDIC rotations, clamped to 0..90
    function automatic longint cordic_angle(longint unsigned adot, longint unsigned adet);
        longint unsigned m;
        int              sh;
        longint          x, y, z, xs, ys;
        m  = (adot > adet) ? adot : adet;
        sh = 0;
        while ((m >> sh) >= (64'd1 << 30)) sh++;
        x = longint'(adot >> sh);
        y = longint'(adet >> sh);
        z = 0;
        for (int i = 0; i < asf_pkg::CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + longint'(asf_pkg::ATAN_DEG[i]);
            end else begin
                x = x - ys; y = y + xs; z = z - longint'(asf_pkg::ATAN_DEG[i]);
            end
        end
        if (z < 0) z = 0;
        if (z > longint'(asf_pkg::DEG90)) z = longint'(asf_pkg::DEG90);
        return z;
    endfunction

    function automatic longint spring_term(longint k, longint c, longint unsigned len);
        longint u;
        u = (c * 64'sd1073741824) / longint'(len);
        return (k * u) >>> 30;
    endfunction

    function automatic longint damp_term(longint v);
        return (model_damp * v) >>> 16;
    endfunction

    function automatic t_force_result predict_forces(logic [asf_pkg::IN_W-1:0] d);
        logic signed [31:0] p[12];
        longint ax, ay, bx, by, v1x, v1y, v3x, v3y;
        longint dot, det, alpha, ang, err, k;
        longint f[4];
        longint unsigned l1, l3;
        t_force_result res;
        for (int i = 0; i < 12; i++) p[i] = d[32*i +: 32];
        ax  = clip_diff(p[0], p[2]);   ay  = clip_diff(p[1], p[3]);
        bx  = clip_diff(p[4], p[2]);   by  = clip_diff(p[5], p[3]);
        v1x = clip_diff(p[6], p[8]);   v1y = clip_diff(p[7], p[9]);
        v3x = clip_diff(p[10], p[8]);  v3y = clip_diff(p[11], p[9]);
        res = '0;
        // zero-length arm: flag only, everything else zero
        if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) begin
            res[asf_pkg::OUT_W] = 1'b1;
            return res;
        end
        l1  = int_sqrt(longint'(ax * ax) + longint'(ay * ay));
        l3  = int_sqrt(longint'(bx * bx) + longint'(by * by));
        dot = ax * bx + ay * by;
        det = ax * by - ay * bx;
        if (det == 0)      alpha = 0;
        else if (dot == 0) alpha = longint'(asf_pkg::DEG90);
        else               alpha = cordic_angle(dot < 0 ? -dot : dot, det < 0 ? -det : det);
        ang = (dot < 0) ? longint'(asf_pkg::DEG180) - alpha : alpha;
        if (det < 0) ang = -ang;
        // an angle of exactly zero counts as non-negative
        err = (ang < 0) ? ang + model_rest : ang - model_rest;
        k   = clip32((model_stiff * err) >>> 16);
        f[0] = -spring_term(k, ay, l1) - damp_term(v1x);
        f[1] =  spring_term(k, ax, l1) - damp_term(v1y);
        f[2] =  spring_term(k, by, l3) - damp_term(v3x);
        f[3] = -spring_term(k, bx, l3) - damp_term(v3y);
        for (int i = 0; i < 4; i++) res[32*i +: 32] = clip32(f[i]);
        res[128 +: asf_pkg::ANG_W] = ang;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [asf_pkg::IN_W-1:0] pack_spring(logic [31:0] v[12]);
        logic [asf_pkg::IN_W-1:0] d;
        for (int i = 0; i < 12; i++) d[32*i +: 32] = v[i];
        return d;
    endfunction

    function automatic logic [31:0] near_val(int span);
        return 32'($signed($urandom_range(2 * span)) - span);
    endfunction

    // Random spring: mostly well-formed geometry, some raw noise and corner shapes
    function automatic logic [asf_pkg::IN_W-1:0] random_spring();
        logic [31:0] v[12];
        int          kind, m;
        kind = $urandom_range(99);
        for (int i = 0; i < 12; i++) v[i] = near_val(1 << 23);
        if (kind < 15) begin
            // raw noise: every bit free
            for (int i = 0; i < 12; i++) v[i] = $urandom;
        end else if (kind < 22) begin
            // one arm of zero length
            if ($urandom_range(1)) begin v[0] = v[2]; v[1] = v[3]; end
            else begin v[4] = v[2]; v[5] = v[3]; end
        end else if (kind < 32) begin
            // collinear arms, same or opposite direction
            m = $urandom_range(6) - 3;
            if (m == 0) m = 2;
            v[0] = v[2] + near_val(1 << 16);
            v[1] = v[3] + near_val(1 << 16);
            v[4] = v[2] + m * (v[0] - v[2]);
            v[5] = v[3] + m * (v[1] - v[3]);
        end else if (kind < 40) begin
            // perpendicular arms
            v[0] = v[2] + near_val(1 << 18);
            v[1] = v[3] + near_val(1 << 18);
            if ($urandom_range(1)) begin
                v[4] = v[2] - (v[1] - v[3]); v[5] = v[3] + (v[0] - v[2]);
            end else begin
                v[4] = v[2] + (v[1] - v[3]); v[5] = v[3] - (v[0] - v[2]);
            end
        end else if (kind < 50) begin
            // far apart: arms and velocity differences may hit the clamp
            for (int i = 0; i < 12; i++)
                v[i] = $urandom_range(1) ? (32'h7FFF_0000 | $urandom_range(65535))
                                         : (32'h8000_0000 | $urandom_range(65535));
        end
        return pack_spring(v);
    endfunction

    task automatic add_directed();
        logic [31:0] v[12];
        logic [31:0] pat[4];
        pat = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        // all zero, then each corner pattern on every field
        for (int j = 0; j < 4; j++) begin
            for (int i = 0; i < 12; i++) v[i] = pat[j];
            spring_queue.insert(spring_queue.size(), pack_spring(v));
        end
        // extremes alternating between fields
        for (int i = 0; i < 12; i++) v[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        spring_queue.insert(spring_queue.size(), pack_spring(v));
        for (int i = 0; i < 12; i++) v[i] = (i % 3) ? 32'h7FFF_FFFF : 32'h8000_0000;
        spring_queue.insert(spring_queue.size(), pack_spring(v));
        // hand-built shapes around a middle at (1,2), velocities varied
        for (int s = 0; s < 8; s++) begin
            for (int i = 6; i < 12; i++) v[i] = near_val(1 << 20);
            v[2] = 32'h0001_0000; v[3] = 32'h0002_0000;
            v[0] = 32'h0003_0000; v[1] = 32'h0002_0000;   // arm a along +x
            case (s)
                0: begin v[4] = 32'h0005_0000; v[5] = 32'h0002_0000; end  // same direction
                1: begin v[4] = 32'hFFFF_0000; v[5] = 32'h0002_0000; end  // opposite, 180
                2: begin v[4] = 32'h0001_0000; v[5] = 32'h0005_0000; end  // +90
                3: begin v[4] = 32'h0001_0000; v[5] = 32'hFFFF_0000; end  // -90
                4: begin v[4] = 32'h0004_0000; v[5] = 32'h0003_0000; end  // small positive
                5: begin v[4] = 32'h0004_0000; v[5] = 32'h0001_0000; end  // small negative
                6: begin v[4] = 32'hFFFC_0000; v[5] = 32'hFFFF_0000; end  // obtuse negative
                default: begin v[4] = v[2]; v[5] = v[3]; end             // third on middle
            endcase
            spring_queue.insert(spring_queue.size(), pack_spring(v));
        end
    endtask

    task automatic apb_write(asf_pkg::t_reg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx) << 2;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            asf_pkg::REG_REST:  model_rest  = longint'(value & 32'h00FF_FFFF);
            asf_pkg::REG_STIFF: model_stiff = longint'(value & 32'h7FFF_FFFF);
            asf_pkg::REG_DAMP:  model_damp  = longint'(value & 32'h7FFF_FFFF);
            default: ;
        endcase
    endtask

    // Hold until every spring has been sent and every result checked, then let
    // the pipeline settle before touching the registers again.
    task automatic wait_drained();
        while (spring_queue.size() != 0 || force_queue.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: advance to the next spring once the current transfer is done
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                force_queue.insert(force_queue.size(), predict_forces(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (spring_queue.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                    s_axis_tdata  <= spring_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each output transfer with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_force_result want;
        logic          bad;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (m_axis_tuser) degen_seen++;
                if (force_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result %h tuser %b",
                                 m_axis_tdata, m_axis_tuser);
                end else begin
                    want = force_queue.pop_front();
                    bad  = 1'b0;
                    for (int i = 0; i < 4; i++)
                        if (m_axis_tdata[32*i +: 32] !== want[32*i +: 32]) bad = 1'b1;
                    if (m_axis_tdata[128 +: asf_pkg::ANG_W] !== want[128 +: asf_pkg::ANG_W])
                        bad = 1'b1;
                    if (m_axis_tuser !== want[asf_pkg::OUT_W]) bad = 1'b1;
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: result %0d forces exp %h %h %h %h got %h %h %h %h",
                                     results_seen, want[0 +: 32], want[32 +: 32],
                                     want[64 +: 32], want[96 +: 32],
                                     m_axis_tdata[0 +: 32], m_axis_tdata[32 +: 32],
                                     m_axis_tdata[64 +: 32], m_axis_tdata[96 +: 32]);
                        if (mismatches <= 10)
                            $display("       angle exp %h got %h, degenerate exp %b got %b",
                                     want[128 +: asf_pkg::ANG_W],
                                     m_axis_tdata[128 +: asf_pkg::ANG_W],
                                     want[asf_pkg::OUT_W], m_axis_tuser);
                    end
                end
            end
        end
    end

    // Drop the run if it hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending", cycles,
                     force_queue.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, then phases of register settings and springs
    // ------------------------------------------------------------------
    initial begin
        logic [31:0] rest_set[N_PHASES];
        logic [31:0] stiff_set[N_PHASES];
        logic [31:0] damp_set[N_PHASES];
        rest_set  = '{32'd0, 32'd11796480, 32'h00FF_FFFF, 32'd2949120, 32'd5898240,
                      32'hFFFF_FFFF};
        stiff_set = '{32'd65536, 32'h7FFF_FFFF, 32'd0, 32'd13107, 32'd1234567,
                      32'hFFFF_FFFF};
        damp_set  = '{32'd0, 32'h7FFF_FFFF, 32'd32768, 32'd65536, 32'd7, 32'hFFFF_FFFF};
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        model_rest    = 0;
        model_stiff   = 0;
        model_damp    = 0;
        snd_idle_pct  = 8;
        rcv_stall_pct = 85;
        mismatches    = 0;
        results_seen  = 0;
        degen_seen    = 0;
        cycles        = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // springs under reset register values first
        add_directed();
        wait_drained();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // idling pattern: sender dense / receiver busy, swapped, then none
            if (ph < 2) begin
                snd_idle_pct = 8;  rcv_stall_pct = 85;
            end else if (ph < 4) begin
                snd_idle_pct = 85; rcv_stall_pct = 8;
            end else begin
                snd_idle_pct = 0;  rcv_stall_pct = 0;
            end
            apb_write(asf_pkg::REG_REST, rest_set[ph]);
            apb_write(asf_pkg::REG_STIFF, stiff_set[ph]);
            apb_write(asf_pkg::REG_DAMP, damp_set[ph]);
            if (ph == 0) add_directed();
            for (int n = 0; n < RAND_PER_PHASE; n++)
                spring_queue.insert(spring_queue.size(), random_spring());
            wait_drained();
        end

        $display("Checked %0d springs (%0d degenerate) over %0d register settings",
                 results_seen, degen_seen, N_PHASES + 1);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatching results", mismatches);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
